// ----- rtl/core/robot_drive_safety_supervisor_defines.svh -----
// ----------------------------------------------------------------------------
// Drive safety supervisor assertion macros
// Shared concurrent assertion forms for the supervisor RTL.
// ----------------------------------------------------------------------------
`ifndef ROBOT_DRIVE_SAFETY_SUPERVISOR_DEFINES_SVH
`define ROBOT_DRIVE_SAFETY_SUPERVISOR_DEFINES_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled while reset is asserted.
`define RDSS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("supervisor assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define RDSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("supervisor assertion failed");

`else

`define RDSS_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define RDSS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/core/rdss_pkg.sv -----
// ----------------------------------------------------------------------------
// Drive safety supervisor package
// Types, codes and reset constants shared by the supervisor RTL.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rdss_pkg;

  localparam int VEL_W      = 16;
  localparam int MV_W       = 16;
  localparam int WD_W       = 16;
  localparam int SPD_W      = 15;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Supervisor states.
  typedef enum logic [2:0] {
    ST_OFF    = 3'd0,
    ST_IDLE   = 3'd1,
    ST_ON     = 3'd2,
    ST_MANUAL = 3'd3,
    ST_REMOTE = 3'd4,
    ST_STOP   = 3'd5,
    ST_BRAKE  = 3'd6
  } state_t;

  // Request kinds.
  typedef enum logic [2:0] {
    MODE_TICK      = 3'd0,
    MODE_DEMAND    = 3'd1,
    MODE_MAN_TRANS = 3'd2,
    MODE_MAN_ROT   = 3'd3,
    MODE_REM_TRANS = 3'd4,
    MODE_REM_ROT   = 3'd5
  } mode_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_CELL    = 2'd0,
    CFG_STOP_SPEED  = 2'd1,
    CFG_MAN_TIMEOUT = 2'd2,
    CFG_REM_TIMEOUT = 2'd3
  } cfg_idx_t;

  localparam logic [MV_W-1:0]  MIN_CELL_RST    = 16'd6100;
  localparam logic [SPD_W-1:0] STOP_SPEED_RST  = 15'd200;
  localparam logic [WD_W-1:0]  MAN_TIMEOUT_RST = 16'd100;
  localparam logic [WD_W-1:0]  REM_TIMEOUT_RST = 16'd100;

  typedef struct packed {
    logic [MV_W-1:0]  min_cell_mv;
    logic [SPD_W-1:0] stop_speed_limit;
    logic [WD_W-1:0]  manual_timeout_ticks;
    logic [WD_W-1:0]  remote_timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic [2:0]              mode;
    logic signed [VEL_W-1:0] value;
    logic                    power_enabled;
    logic                    brake_engaged;
    logic [MV_W-1:0]         battery_front_mv;
    logic [MV_W-1:0]         battery_middle_mv;
    logic [MV_W-1:0]         battery_rear_mv;
    logic signed [VEL_W-1:0] measured_translational;
    logic signed [VEL_W-1:0] measured_rotational;
  } in_item_t;

  typedef struct packed {
    logic [2:0]              state_now;
    logic                    warn_lamp;
    logic                    stop_front;
    logic                    stop_rear;
    logic                    drive_write;
    logic signed [VEL_W-1:0] drive_translational;
    logic signed [VEL_W-1:0] drive_rotational;
    logic                    drive_start;
    logic                    drive_stop;
  } out_item_t;

  // True when the stored demand code equals the given state code.
  function automatic logic dem_is(logic signed [VEL_W-1:0] dem, state_t st);
    return dem == {{(VEL_W-3){1'b0}}, st};
  endfunction

  // Demand code for a state.
  function automatic logic signed [VEL_W-1:0] dem_of(state_t st);
    return {{(VEL_W-3){1'b0}}, st};
  endfunction

endpackage

// ----- rtl/core/rdss_channels.sv -----
// ----------------------------------------------------------------------------
// Drive safety supervisor channels
// Valid/ready channel interfaces for requests and results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rdss_in_if;
  import rdss_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rdss_out_if;
  import rdss_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/robot_drive_safety_supervisor.sv -----
// ----------------------------------------------------------------------------
// Robot drive safety supervisor
// A request is held in the input register, then its result in the result
// register. Throughput: one request per cycle unless results stall; the state
// registers update in one pass. Back-pressure on the result side stalls the
// input register only when full. Reset: synchronous, active low; state, valid
// flags and configuration return to their defaults at once; data is not reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "robot_drive_safety_supervisor_defines.svh"

module robot_drive_safety_supervisor (
  input  logic                             clk,
  input  logic                             rst_n,
  rdss_in_if.sink                          in_chan,
  rdss_out_if.source                       out_chan,
  input  logic                             cfg_we,
  input  logic [rdss_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [rdss_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import rdss_pkg::*;

  cfg_t      cfg;
  in_item_t  in_data_r;
  logic      in_valid_r;
  out_item_t out_data_r;
  logic      out_valid_r;
  out_item_t result;
  logic      advance;

  rdss_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  rdss_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .step   (advance),
    .item   (in_data_r),
    .result (result)
  );

  // A request moves on when the result register is free or being drained.
  assign advance       = in_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !in_valid_r || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_chan.valid && in_chan.ready) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      in_data_r <= in_chan.data;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= result;
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;

  // A start pulse only comes with a command on entry to the on state.
  `RDSS_ASSERT_NOW(a_start_on, clk, rst_n, out_valid_r && out_data_r.drive_start,
    out_data_r.drive_write && out_data_r.state_now == ST_ON)
  // A stop pulse only comes on entry to brake with both scanners stopped.
  `RDSS_ASSERT_NOW(a_stop_brake, clk, rst_n, out_valid_r && out_data_r.drive_stop,
    out_data_r.state_now == ST_BRAKE && out_data_r.stop_front && out_data_r.stop_rear)
  // Without a command the velocity fields are zero.
  `RDSS_ASSERT_NOW(a_idle_vel, clk, rst_n, out_valid_r && !out_data_r.drive_write,
    out_data_r.drive_translational == '0 && out_data_r.drive_rotational == '0)
  // An accepted request always lands in the input register.
  `RDSS_ASSERT_NEXT(a_in_load, clk, rst_n, in_chan.valid && in_chan.ready, in_valid_r)

endmodule

// ----- rtl/core/rdss_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// Drive safety supervisor configuration registers
// Write-only register file for thresholds and watchdog timeouts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rdss_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [rdss_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [rdss_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output rdss_pkg::cfg_t                   cfg
);
  import rdss_pkg::*;

  cfg_t cfg_r;

  // Register writes; the stop speed register keeps the low 15 bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_cell_mv          <= MIN_CELL_RST;
      cfg_r.stop_speed_limit     <= STOP_SPEED_RST;
      cfg_r.manual_timeout_ticks <= MAN_TIMEOUT_RST;
      cfg_r.remote_timeout_ticks <= REM_TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_idx))
        CFG_MIN_CELL:    cfg_r.min_cell_mv          <= cfg_wdata[MV_W-1:0];
        CFG_STOP_SPEED:  cfg_r.stop_speed_limit     <= cfg_wdata[SPD_W-1:0];
        CFG_MAN_TIMEOUT: cfg_r.manual_timeout_ticks <= cfg_wdata[WD_W-1:0];
        CFG_REM_TIMEOUT: cfg_r.remote_timeout_ticks <= cfg_wdata[WD_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- rtl/core/rdss_ctrl.sv -----
// ----------------------------------------------------------------------------
// Drive safety supervisor control
// State registers and single-pass next-state and result logic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "robot_drive_safety_supervisor_defines.svh"

module rdss_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rdss_pkg::cfg_t       cfg,
  input  logic                 step,
  input  rdss_pkg::in_item_t   item,
  output rdss_pkg::out_item_t  result
);
  import rdss_pkg::*;

  state_t                  state_r, state_nxt;
  logic signed [VEL_W-1:0] dem_r, dem_nxt;
  logic                    lamp_r, lamp_nxt;
  logic                    fstop_r, fstop_nxt;
  logic                    rstop_r, rstop_nxt;
  logic signed [VEL_W-1:0] man_trans_r, man_trans_nxt;
  logic signed [VEL_W-1:0] man_rot_r, man_rot_nxt;
  logic signed [VEL_W-1:0] rem_trans_r, rem_trans_nxt;
  logic signed [VEL_W-1:0] rem_rot_r, rem_rot_nxt;
  logic [WD_W-1:0]         man_wd_r, man_wd_nxt;
  logic [WD_W-1:0]         rem_wd_r, rem_wd_nxt;

  logic [WD_W-1:0]         man_wd_inc, rem_wd_inc;
  logic                    all_ok, any_low, slow;
  logic                    pwr, brk;
  logic                    wr, start, stp;
  logic signed [VEL_W-1:0] dt, dr;

  // Saturating watchdog increments used on a tick.
  assign man_wd_inc = (man_wd_r == '1) ? man_wd_r : man_wd_r + 1'b1;
  assign rem_wd_inc = (rem_wd_r == '1) ? rem_wd_r : rem_wd_r + 1'b1;

  // Battery and speed checks on the sampled tick inputs.
  assign all_ok  = (item.battery_front_mv  >= cfg.min_cell_mv) &&
                   (item.battery_middle_mv >= cfg.min_cell_mv) &&
                   (item.battery_rear_mv   >= cfg.min_cell_mv);
  assign any_low = (item.battery_front_mv  <= cfg.min_cell_mv) ||
                   (item.battery_middle_mv <= cfg.min_cell_mv) ||
                   (item.battery_rear_mv   <= cfg.min_cell_mv);
  assign slow    = (item.measured_rotational    <= $signed({1'b0, cfg.stop_speed_limit})) &&
                   (item.measured_translational <= $signed({1'b0, cfg.stop_speed_limit}));
  assign pwr     = item.power_enabled;
  assign brk     = item.brake_engaged;

  // Next state and result for one request.
  always_comb begin
    state_nxt     = state_r;
    dem_nxt       = dem_r;
    lamp_nxt      = lamp_r;
    fstop_nxt     = fstop_r;
    rstop_nxt     = rstop_r;
    man_trans_nxt = man_trans_r;
    man_rot_nxt   = man_rot_r;
    rem_trans_nxt = rem_trans_r;
    rem_rot_nxt   = rem_rot_r;
    man_wd_nxt    = man_wd_r;
    rem_wd_nxt    = rem_wd_r;
    wr            = 1'b0;
    start         = 1'b0;
    stp           = 1'b0;
    dt            = '0;
    dr            = '0;

    unique case (mode_t'(item.mode))
      MODE_DEMAND: begin
        dem_nxt = item.value;
      end
      MODE_MAN_TRANS: begin
        man_trans_nxt = item.value;
        man_wd_nxt    = '0;
      end
      MODE_MAN_ROT: begin
        man_rot_nxt = item.value;
        man_wd_nxt  = '0;
      end
      MODE_REM_TRANS: begin
        rem_trans_nxt = item.value;
        rem_wd_nxt    = '0;
      end
      MODE_REM_ROT: begin
        rem_rot_nxt = item.value;
        rem_wd_nxt  = '0;
      end
      MODE_TICK: begin
        man_wd_nxt = man_wd_inc;
        rem_wd_nxt = rem_wd_inc;
        unique case (state_r) inside
          ST_OFF: begin
            if (!brk) begin
              lamp_nxt  = 1'b0;
              fstop_nxt = 1'b1;
              rstop_nxt = 1'b1;
            end else if (pwr) begin
              lamp_nxt  = 1'b1;
              fstop_nxt = 1'b0;
              rstop_nxt = 1'b0;
              dem_nxt   = dem_of(ST_IDLE);
              state_nxt = ST_IDLE;
            end else begin
              lamp_nxt  = 1'b0;
              fstop_nxt = 1'b0;
              rstop_nxt = 1'b0;
            end
          end
          ST_IDLE: begin
            lamp_nxt = 1'b0;
            if (!pwr) begin
              state_nxt = ST_OFF;
            end else if (brk) begin
              state_nxt = ST_IDLE;
            end else if (dem_is(dem_r, ST_OFF)) begin
              state_nxt = ST_OFF;
            end else if (dem_is(dem_r, ST_ON) || dem_is(dem_r, ST_MANUAL) ||
                         dem_is(dem_r, ST_REMOTE)) begin
              if (all_ok) begin
                lamp_nxt      = 1'b1;
                man_trans_nxt = '0;
                man_rot_nxt   = '0;
                rem_trans_nxt = '0;
                rem_rot_nxt   = '0;
                wr            = 1'b1;
                start         = 1'b1;
                state_nxt     = ST_ON;
              end else begin
                dem_nxt = dem_of(ST_OFF);
              end
            end
          end
          ST_ON, ST_MANUAL, ST_REMOTE: begin
            if (!pwr || brk || any_low || dem_is(dem_r, ST_OFF)) begin
              lamp_nxt  = 1'b1;
              dem_nxt   = dem_of(ST_OFF);
              state_nxt = ST_STOP;
            end else if (state_r != ST_ON && dem_is(dem_r, ST_ON)) begin
              state_nxt = ST_ON;
            end else if (state_r != ST_MANUAL && dem_is(dem_r, ST_MANUAL)) begin
              state_nxt = ST_MANUAL;
            end else if (state_r != ST_REMOTE && dem_is(dem_r, ST_REMOTE)) begin
              state_nxt = ST_REMOTE;
            end else if (state_r == ST_ON) begin
              wr            = 1'b1;
              man_trans_nxt = '0;
              man_rot_nxt   = '0;
              rem_trans_nxt = '0;
              rem_rot_nxt   = '0;
              lamp_nxt      = 1'b1;
            end else if (state_r == ST_MANUAL) begin
              wr = 1'b1;
              if (man_wd_inc > cfg.manual_timeout_ticks) begin
                man_trans_nxt = '0;
                man_rot_nxt   = '0;
              end else begin
                dt       = man_trans_r;
                dr       = man_rot_r;
                lamp_nxt = 1'b1;
              end
            end else begin
              wr = 1'b1;
              if (rem_wd_inc > cfg.remote_timeout_ticks) begin
                rem_trans_nxt = '0;
                rem_rot_nxt   = '0;
              end else begin
                dt       = rem_trans_r;
                dr       = rem_rot_r;
                lamp_nxt = 1'b1;
              end
            end
          end
          ST_STOP: begin
            wr = 1'b1;
            if (slow) begin
              fstop_nxt = 1'b1;
              rstop_nxt = 1'b1;
              stp       = 1'b1;
              state_nxt = ST_BRAKE;
            end else begin
              lamp_nxt = 1'b1;
            end
          end
          ST_BRAKE: begin
            if (pwr) begin
              fstop_nxt = 1'b1;
              rstop_nxt = 1'b1;
              lamp_nxt  = 1'b1;
            end else if (!brk) begin
              lamp_nxt = 1'b1;
            end else begin
              fstop_nxt = 1'b0;
              rstop_nxt = 1'b0;
              lamp_nxt  = 1'b0;
              state_nxt = ST_OFF;
            end
          end
          default: begin
            state_nxt = ST_OFF;
          end
        endcase
      end
      default: ;
    endcase
  end

  // State registers advance only when a request passes this stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_OFF;
      dem_r       <= '0;
      lamp_r      <= 1'b0;
      fstop_r     <= 1'b0;
      rstop_r     <= 1'b0;
      man_trans_r <= '0;
      man_rot_r   <= '0;
      rem_trans_r <= '0;
      rem_rot_r   <= '0;
      man_wd_r    <= '0;
      rem_wd_r    <= '0;
    end else if (step) begin
      state_r     <= state_nxt;
      dem_r       <= dem_nxt;
      lamp_r      <= lamp_nxt;
      fstop_r     <= fstop_nxt;
      rstop_r     <= rstop_nxt;
      man_trans_r <= man_trans_nxt;
      man_rot_r   <= man_rot_nxt;
      rem_trans_r <= rem_trans_nxt;
      rem_rot_r   <= rem_rot_nxt;
      man_wd_r    <= man_wd_nxt;
      rem_wd_r    <= rem_wd_nxt;
    end
  end

  // Result fields reflect the levels after this request.
  always_comb begin
    result.state_now           = state_nxt;
    result.warn_lamp           = lamp_nxt;
    result.stop_front          = fstop_nxt;
    result.stop_rear           = rstop_nxt;
    result.drive_write         = wr;
    result.drive_translational = dt;
    result.drive_rotational    = dr;
    result.drive_start         = start;
    result.drive_stop          = stp;
  end

  // The supervisor state only moves with an accepted request.
  `RDSS_ASSERT_NEXT(a_state_holds, clk, rst_n, !step, $stable(state_r))

endmodule

// ----- tb/robot_drive_safety_supervisor_tb.sv -----
// ----------------------------------------------------------------------------
// Drive safety supervisor testbench
// Drives ticks and write events through the request channel and checks every
// status result against a cycle-free model of the supervisor state machine.
// A directed walk through all states comes first, then state-aware random
// traffic over several register settings and handshake idling patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module robot_drive_safety_supervisor_tb;
  import rdss_pkg::*;

  // Request kinds that the block has no use for.
  localparam logic [2:0] MODE_SPARE_A = 3'd6;
  localparam logic [2:0] MODE_SPARE_B = 3'd7;

  localparam logic signed [VEL_W-1:0] SPD_EDGE = 16'(STOP_SPEED_RST);

  // Tracks the supervisor state and holds the status results still owed.
  class supervisor_tracker;
    logic [15:0]        min_cell;
    logic [14:0]        stop_lim;
    logic [15:0]        man_limit;
    logic [15:0]        rem_limit;
    state_t             cur_state;
    logic signed [15:0] demand;
    logic               lamp;
    logic               front_stop;
    logic               rear_stop;
    logic signed [15:0] man_vel [2];
    logic signed [15:0] rem_vel [2];
    logic [15:0]        man_wd;
    logic [15:0]        rem_wd;
    out_item_t          status_q [$];
    int                 errors;
    int                 results;

    function new();
      min_cell   = MIN_CELL_RST;
      stop_lim   = STOP_SPEED_RST;
      man_limit  = MAN_TIMEOUT_RST;
      rem_limit  = REM_TIMEOUT_RST;
      cur_state  = ST_OFF;
      demand     = '0;
      lamp       = 1'b0;
      front_stop = 1'b0;
      rear_stop  = 1'b0;
      zero_drives(1'b1, 1'b1);
      man_wd     = '0;
      rem_wd     = '0;
      errors     = 0;
      results    = 0;
    endfunction

    function void set_config(cfg_idx_t idx, logic [15:0] data);
      case (idx)
        CFG_MIN_CELL:    min_cell = data;
        CFG_STOP_SPEED:  stop_lim = data[14:0];
        CFG_MAN_TIMEOUT: man_limit = data;
        CFG_REM_TIMEOUT: rem_limit = data;
        default: ;
      endcase
    endfunction

    function bit demand_is(state_t s);
      return demand == 16'(s);
    endfunction

    function bit demand_runs();
      return demand_is(ST_ON) || demand_is(ST_MANUAL) || demand_is(ST_REMOTE);
    endfunction

    function void zero_drives(bit manual, bit remote);
      if (manual) begin
        man_vel[0] = '0;
        man_vel[1] = '0;
      end
      if (remote) begin
        rem_vel[0] = '0;
        rem_vel[1] = '0;
      end
    endfunction

    function int pending();
      return status_q.size();
    endfunction

    // One supervisor tick: watchdogs, then the state machine. Returns the
    // drive command fields; the level fields are filled in by the caller.
    function out_item_t advance_tick(in_item_t rq);
      out_item_t          r;
      bit                 pwr;
      bit                 brk;
      bit                 all_ok;
      bit                 any_low;
      logic signed [15:0] mt;
      logic signed [15:0] mr;
      r       = '0;
      pwr     = rq.power_enabled;
      brk     = rq.brake_engaged;
      mt      = rq.measured_translational;
      mr      = rq.measured_rotational;
      all_ok  = rq.battery_front_mv >= min_cell && rq.battery_middle_mv >= min_cell &&
                rq.battery_rear_mv >= min_cell;
      any_low = rq.battery_front_mv <= min_cell || rq.battery_middle_mv <= min_cell ||
                rq.battery_rear_mv <= min_cell;

      if (man_wd != 16'hFFFF) man_wd = man_wd + 16'd1;
      if (rem_wd != 16'hFFFF) rem_wd = rem_wd + 16'd1;

      case (cur_state)
        ST_OFF: begin
          if (!brk) begin
            lamp = 1'b0; front_stop = 1'b1; rear_stop = 1'b1;
          end else if (pwr) begin
            lamp = 1'b1; front_stop = 1'b0; rear_stop = 1'b0;
            demand = 16'(ST_IDLE);
            cur_state = ST_IDLE;
          end else begin
            lamp = 1'b0; front_stop = 1'b0; rear_stop = 1'b0;
          end
        end
        ST_IDLE: begin
          if (!pwr) begin
            lamp = 1'b0;
            cur_state = ST_OFF;
          end else if (brk) begin
            lamp = 1'b0;
          end else if (demand_is(ST_OFF)) begin
            lamp = 1'b0;
            cur_state = ST_OFF;
          end else if (demand_runs()) begin
            if (all_ok) begin
              lamp = 1'b1;
              zero_drives(1'b1, 1'b1);
              r.drive_write = 1'b1;
              r.drive_start = 1'b1;
              cur_state = ST_ON;
            end else begin
              lamp = 1'b0;
              demand = 16'(ST_OFF);
            end
          end else begin
            lamp = 1'b0;
          end
        end
        ST_ON, ST_MANUAL, ST_REMOTE: begin
          if (!pwr || brk || any_low || demand_is(ST_OFF)) begin
            lamp = 1'b1;
            demand = 16'(ST_OFF);
            cur_state = ST_STOP;
          end else if (cur_state != ST_ON && demand_is(ST_ON)) begin
            cur_state = ST_ON;
          end else if (cur_state != ST_MANUAL && demand_is(ST_MANUAL)) begin
            cur_state = ST_MANUAL;
          end else if (cur_state != ST_REMOTE && demand_is(ST_REMOTE)) begin
            cur_state = ST_REMOTE;
          end else if (cur_state == ST_ON) begin
            r.drive_write = 1'b1;
            zero_drives(1'b1, 1'b1);
            lamp = 1'b1;
          end else if (cur_state == ST_MANUAL) begin
            r.drive_write = 1'b1;
            if (man_wd > man_limit) begin
              zero_drives(1'b1, 1'b0);
            end else begin
              r.drive_translational = man_vel[0];
              r.drive_rotational    = man_vel[1];
              lamp = 1'b1;
            end
          end else begin
            r.drive_write = 1'b1;
            if (rem_wd > rem_limit) begin
              zero_drives(1'b0, 1'b1);
            end else begin
              r.drive_translational = rem_vel[0];
              r.drive_rotational    = rem_vel[1];
              lamp = 1'b1;
            end
          end
        end
        ST_STOP: begin
          // Signed compare against the limit, with no absolute value taken.
          r.drive_write = 1'b1;
          if (int'(mr) <= int'(stop_lim) && int'(mt) <= int'(stop_lim)) begin
            front_stop = 1'b1; rear_stop = 1'b1;
            r.drive_stop = 1'b1;
            cur_state = ST_BRAKE;
          end else begin
            lamp = 1'b1;
          end
        end
        ST_BRAKE: begin
          if (pwr) begin
            front_stop = 1'b1; rear_stop = 1'b1; lamp = 1'b1;
          end else if (!brk) begin
            lamp = 1'b1;
          end else begin
            front_stop = 1'b0; rear_stop = 1'b0; lamp = 1'b0;
            cur_state = ST_OFF;
          end
        end
        default: cur_state = ST_OFF;
      endcase
      return r;
    endfunction

    // Applies an accepted request and queues the status it must produce.
    function void note_request(in_item_t rq);
      out_item_t r;
      r = '0;
      case (rq.mode)
        MODE_TICK:      r = advance_tick(rq);
        MODE_DEMAND:    demand = rq.value;
        MODE_MAN_TRANS: begin man_vel[0] = rq.value; man_wd = '0; end
        MODE_MAN_ROT:   begin man_vel[1] = rq.value; man_wd = '0; end
        MODE_REM_TRANS: begin rem_vel[0] = rq.value; rem_wd = '0; end
        MODE_REM_ROT:   begin rem_vel[1] = rq.value; rem_wd = '0; end
        default: ;
      endcase
      r.state_now  = cur_state;
      r.warn_lamp  = lamp;
      r.stop_front = front_stop;
      r.stop_rear  = rear_stop;
      status_q.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      $display("[%0t] MISMATCH %s", $time, msg);
    endtask

    task match_field(string field, int got, int want);
      if (got != want)
        report($sformatf("result %0d %s: got %0d, expected %0d", results, field, got, want));
    endtask

    task check_status(out_item_t got);
      out_item_t want;
      results++;
      if (status_q.size() == 0) begin
        report($sformatf("result %0d arrived with nothing outstanding", results));
        return;
      end
      want = status_q.pop_front();
      match_field("state_now", got.state_now, want.state_now);
      match_field("warn_lamp", got.warn_lamp, want.warn_lamp);
      match_field("stop_front", got.stop_front, want.stop_front);
      match_field("stop_rear", got.stop_rear, want.stop_rear);
      match_field("drive_write", got.drive_write, want.drive_write);
      match_field("drive_translational", got.drive_translational,
                  want.drive_translational);
      match_field("drive_rotational", got.drive_rotational, want.drive_rotational);
      match_field("drive_start", got.drive_start, want.drive_start);
      match_field("drive_stop", got.drive_stop, want.drive_stop);
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [15:0] cfg_wdata;

  rdss_in_if  in_chan ();
  rdss_out_if out_chan ();

  supervisor_tracker tracker = new();

  int unsigned gap_pct   = 0;
  int unsigned stall_pct = 0;
  int          hold_left = 0;

  robot_drive_safety_supervisor u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Result side: a long hold-off takes priority over random stalls.
  initial begin
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_chan.ready = 1'b0;
        hold_left--;
      end else begin
        out_chan.ready = $urandom_range(0, 99) >= stall_pct;
      end
    end
  end

  // Both handshakes are observed here, the request before the result.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_chan.valid && in_chan.ready) tracker.note_request(in_chan.data);
      if (out_chan.valid && out_chan.ready) tracker.check_status(out_chan.data);
    end
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", tracker.pending());
    $display("DONE: errors detected");
    $finish;
  end

  // Offers one request, after an optional random gap, and waits for it to go.
  task send_request(in_item_t rq);
    @(negedge clk);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_chan.valid = 1'b0;
      @(negedge clk);
    end
    in_chan.valid = 1'b1;
    in_chan.data  = rq;
    do begin
      @(posedge clk);
    end while (!in_chan.ready);
  endtask

  task wait_drained();
    @(negedge clk);
    in_chan.valid = 1'b0;
    while (tracker.pending() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task write_config(cfg_idx_t idx, logic [15:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
    tracker.set_config(idx, data);
  endtask

  function automatic in_item_t tick_item(bit pwr, bit brk, logic [15:0] rear_mv,
                                         logic signed [15:0] mt, logic signed [15:0] mr);
    in_item_t r;
    r = '0;
    r.mode                   = MODE_TICK;
    r.power_enabled          = pwr;
    r.brake_engaged          = brk;
    r.battery_front_mv       = 16'hFFFF;
    r.battery_middle_mv      = 16'hFFFF;
    r.battery_rear_mv        = rear_mv;
    r.measured_translational = mt;
    r.measured_rotational    = mr;
    return r;
  endfunction

  function automatic in_item_t write_item(logic [2:0] mode, logic signed [15:0] value);
    in_item_t r;
    r = '0;
    r.mode  = mode;
    r.value = value;
    return r;
  endfunction

  function automatic logic [15:0] healthy_cell();
    if (tracker.min_cell == 16'hFFFF) return 16'hFFFF;
    return 16'($urandom_range(int'(tracker.min_cell) + 1, 65535));
  endfunction

  // A cell at the threshold counts as low for running but fine for starting.
  function automatic logic [15:0] weak_cell();
    if ($urandom_range(0, 1) == 0 || tracker.min_cell == 16'd0) return tracker.min_cell;
    return 16'($urandom_range(0, int'(tracker.min_cell) - 1));
  endfunction

  function automatic in_item_t with_cells(in_item_t rq, int unsigned healthy_pct);
    int low_idx;
    low_idx = ($urandom_range(0, 99) < healthy_pct) ? -1 : int'($urandom_range(0, 2));
    rq.battery_front_mv  = (low_idx == 0) ? weak_cell() : healthy_cell();
    rq.battery_middle_mv = (low_idx == 1) ? weak_cell() : healthy_cell();
    rq.battery_rear_mv   = (low_idx == 2) ? weak_cell() : healthy_cell();
    return rq;
  endfunction

  function automatic logic signed [15:0] velocity();
    if ($urandom_range(0, 3) == 0) return 16'($urandom);
    return 16'(int'($urandom_range(0, 4000)) - 2000);
  endfunction

  // Measured speeds mostly at or under the stop limit, so braking follows.
  function automatic logic signed [15:0] stop_speed();
    int v;
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 10) return 16'(tracker.stop_lim);
    if (p < 35) return 16'($urandom);
    v = int'(tracker.stop_lim) - int'($urandom_range(0, 3000));
    if (v < -32768) v = -32768;
    return 16'(v);
  endfunction

  function automatic logic signed [15:0] demand_code();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 28) return 16'(ST_ON);
    if (p < 56) return 16'(ST_MANUAL);
    if (p < 84) return 16'(ST_REMOTE);
    if (p < 92) return 16'(ST_OFF);
    return 16'($urandom);
  endfunction

  function automatic in_item_t random_fields();
    in_item_t r;
    r.mode                   = 3'($urandom_range(0, 5));
    r.value                  = 16'($urandom);
    r.power_enabled          = 1'($urandom);
    r.brake_engaged          = 1'($urandom);
    r.battery_front_mv       = 16'($urandom);
    r.battery_middle_mv      = 16'($urandom);
    r.battery_rear_mv        = 16'($urandom);
    r.measured_translational = 16'($urandom);
    r.measured_rotational    = 16'($urandom);
    return r;
  endfunction

  // Steers the next request from the tracked state so that most sequences
  // get past idle into the running states; a small share stays pure noise.
  function automatic in_item_t next_request();
    in_item_t    r;
    int unsigned p;
    r = random_fields();
    if ($urandom_range(0, 99) < 6) begin
      if ($urandom_range(0, 3) == 0)
        r.mode = ($urandom_range(0, 1) != 0) ? MODE_SPARE_A : MODE_SPARE_B;
      return r;
    end
    p = $urandom_range(0, 99);
    case (tracker.cur_state)
      ST_OFF: begin
        r.mode          = MODE_TICK;
        r.brake_engaged = p < 80;
        r.power_enabled = $urandom_range(0, 99) < 80;
      end
      ST_IDLE: begin
        if (!tracker.demand_runs() && p < 50) begin
          r.mode  = MODE_DEMAND;
          r.value = demand_code();
        end else begin
          r.mode          = MODE_TICK;
          r.power_enabled = $urandom_range(0, 99) < 95;
          r.brake_engaged = $urandom_range(0, 99) < 8;
          r = with_cells(r, 85);
        end
      end
      ST_STOP: begin
        r.mode                   = MODE_TICK;
        r.measured_translational = stop_speed();
        r.measured_rotational    = stop_speed();
      end
      ST_BRAKE: r.mode = MODE_TICK;
      default: begin
        if (p < 25) begin
          r.mode  = 3'($urandom_range(MODE_MAN_TRANS, MODE_REM_ROT));
          r.value = velocity();
        end else if (p < 35) begin
          r.mode  = MODE_DEMAND;
          r.value = demand_code();
        end else begin
          r.mode          = MODE_TICK;
          r.power_enabled = $urandom_range(0, 99) < 98;
          r.brake_engaged = $urandom_range(0, 99) < 2;
          r = with_cells(r, 97);
        end
      end
    endcase
    return r;
  endfunction

  // Sets the idling pattern and writes all four registers for a phase.
  task configure(int phase);
    logic [15:0] mc;
    logic [15:0] spd;
    logic [15:0] man;
    logic [15:0] rem;
    case (phase)
      0: begin
        mc = MIN_CELL_RST; spd = 16'(STOP_SPEED_RST);
        man = MAN_TIMEOUT_RST; rem = REM_TIMEOUT_RST;
        gap_pct = 0; stall_pct = 0;
      end
      1: begin
        mc = 16'd0; spd = 16'h7FFF; man = 16'd0; rem = 16'hFFFF;
        gap_pct = 76; stall_pct = 0;
      end
      2: begin
        mc = 16'hFFFF; spd = 16'd0; man = 16'hFFFF; rem = 16'd0;
        gap_pct = 0; stall_pct = 76;
      end
      3: begin
        mc = 16'($urandom_range(5000, 7000)); spd = 16'($urandom_range(0, 1500));
        man = 16'($urandom_range(1, 8)); rem = 16'($urandom_range(1, 8));
        gap_pct = 31; stall_pct = 31;
      end
      4: begin
        mc = 16'($urandom); spd = 16'($urandom_range(0, 32767));
        man = 16'($urandom_range(1, 30)); rem = 16'($urandom_range(1, 30));
        gap_pct = 0; stall_pct = 0;
      end
      default: begin
        mc = MIN_CELL_RST; spd = 16'($urandom_range(0, 500));
        man = 16'd2; rem = 16'd5;
        gap_pct = 31; stall_pct = 31;
      end
    endcase
    write_config(CFG_MIN_CELL, mc);
    write_config(CFG_STOP_SPEED, spd);
    write_config(CFG_MAN_TIMEOUT, man);
    write_config(CFG_REM_TIMEOUT, rem);
  endtask

  // Walk through every state with the reset register values.
  task directed_walk();
    // Off: unbraked sets both scanner stops, braked without power clears them.
    send_request(tick_item(1'b0, 1'b0, 16'hFFFF, '0, '0));
    send_request(tick_item(1'b0, 1'b1, 16'hFFFF, '0, '0));
    send_request(tick_item(1'b1, 1'b1, 16'hFFFF, '0, '0));
    // Idle with a demand code that is not a running state.
    send_request(write_item(MODE_DEMAND, 16'(ST_STOP)));
    send_request(tick_item(1'b1, 1'b0, 16'hFFFF, '0, '0));
    // A low cell refuses the start and clears the demand, then idle drops to off.
    send_request(write_item(MODE_DEMAND, 16'(ST_ON)));
    send_request(tick_item(1'b1, 1'b0, MIN_CELL_RST - 16'd1, '0, '0));
    send_request(tick_item(1'b1, 1'b0, 16'hFFFF, '0, '0));
    send_request(tick_item(1'b1, 1'b1, 16'hFFFF, '0, '0));
    // A cell exactly at the threshold still allows the start.
    send_request(write_item(MODE_DEMAND, 16'(ST_MANUAL)));
    send_request(tick_item(1'b1, 1'b0, MIN_CELL_RST, '0, '0));
    send_request(tick_item(1'b1, 1'b0, 16'hFFFF, '0, '0));
    send_request(write_item(MODE_MAN_TRANS, 16'sh7FFF));
    send_request(write_item(MODE_MAN_ROT, 16'sh8000));
    send_request(tick_item(1'b1, 1'b0, 16'hFFFF, '0, '0));
    send_request(write_item(MODE_REM_TRANS, -16'sd1));
    send_request(write_item(MODE_REM_ROT, 16'sd1));
    send_request(write_item(MODE_DEMAND, 16'(ST_REMOTE)));
    send_request(tick_item(1'b1, 1'b0, 16'hFFFF, '0, '0));
    send_request(tick_item(1'b1, 1'b0, 16'hFFFF, '0, '0));
    send_request(write_item(MODE_SPARE_A, 16'sh1234));
    // The same threshold cell now counts as low and forces a stop.
    send_request(tick_item(1'b1, 1'b0, MIN_CELL_RST, '0, '0));
    send_request(tick_item(1'b1, 1'b0, 16'hFFFF, SPD_EDGE + 16'sd1, 16'sh8000));
    send_request(tick_item(1'b1, 1'b0, 16'hFFFF, SPD_EDGE, 16'sh8000));
    send_request(tick_item(1'b1, 1'b0, 16'hFFFF, '0, '0));
    send_request(tick_item(1'b0, 1'b1, 16'hFFFF, '0, '0));
  endtask

  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = CFG_MIN_CELL;
    cfg_wdata     = '0;
    in_chan.valid = 1'b0;
    in_chan.data  = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(posedge clk);

    for (int phase = 0; phase < 6; phase++) begin
      configure(phase);
      if (phase == 0) directed_walk();
      // Long result hold-off while requests keep coming, to fill the block.
      if (phase == 4) begin
        @(posedge clk);
        hold_left = 80;
      end
      for (int n = 0; n < 100; n++) begin
        if (phase == 3 && n == 50) wait_drained();
        send_request(next_request());
      end
      wait_drained();
    end

    if (tracker.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
